[hw/rtl/fpeb_pkg.sv]
// Package with the shared command types of the file placement evict/bring policy block.
package fpeb_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned ENTRY_W = 7;
  localparam int unsigned TIME_W = 31;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 8;
  localparam logic [TIME_W-1:0] THRESHOLD_RESET = 31'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_HANDLE  = 3'd2,
    MODE_EVICT   = 3'd3,
    MODE_BRING   = 3'd4,
    MODE_PLACE   = 3'd5,
    MODE_ALL_MEM = 3'd6,
    MODE_REMOVE  = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [ENTRY_W-1:0] entry;
    logic              is_file;
    logic              flag;
    logic              place;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

endpackage

[hw/rtl/file_placement_evict_bring_policy.sv]
// Top level of the file placement evict/bring policy block.
// Each command transfer yields exactly one result transfer. Find evict, find bring
// and all memory walk the table one entry per cycle through its single read port,
// and find evict walks it a second time when no closed in-memory file exists. A
// two-deep command queue lets new commands be taken while a result waits. The table
// needs no clearing after reset, so commands are taken at once.
module file_placement_evict_bring_policy import fpeb_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIME_W-1:0]     cfg_data,       // stay_threshold
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // entry, is_file, flag, place, now
  input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // found, result_entry
);

  queue_out_t q;
  logic       q_pop;

  fpeb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_out         (q),
    .q_pop         (q_pop)
  );

  fpeb_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .q_in          (q),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[hw/rtl/fpeb_front.sv]
// Front part: accepts command transfers, decodes them and queues them for the back part.
module fpeb_front import fpeb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output queue_out_t            q_out,
  input  logic                  q_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.mode    = mode_t'(s_axis_tuser);
    in_cmd.entry   = s_axis_tdata[6:0];
    in_cmd.is_file = s_axis_tdata[7];
    in_cmd.flag    = s_axis_tdata[8];
    in_cmd.place   = s_axis_tdata[9];
    in_cmd.now     = s_axis_tdata[40:10];
  end

  assign s_axis_tready = (fill != 2'd2);
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop = q_pop && (fill != 2'd0);
  assign q_out.valid = (fill != 2'd0);
  assign q_out.cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/fpeb_back.sv]
// Back part: entry table memory, command sequencer, table scans and the result register.
module fpeb_back import fpeb_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIME_W-1:0]     cfg_data,
  input  queue_out_t            q_in,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW = IDX_W + 1;
  localparam int unsigned CW = (EW > ENTRY_W) ? EW : ENTRY_W;
  localparam logic [3:0] PEN_EXP_MAX = 4'd15;

  typedef struct packed {
    logic        is_file;
    logic        is_open;
    logic        handle;
    logic        on_disk;
    logic [3:0]  pen_exp;
    logic [31:0] time_in;
    logic [31:0] time_out;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TGT_WR, S_SCAN, S_DONE} state_t;

  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  state_t            state;
  cmd_t              cmd;
  logic [EW-1:0]     count;
  logic [EW-1:0]     issue_idx;
  logic [IDX_W-1:0]  eval_idx;
  logic              pend;
  logic              pass;
  logic              res_found;
  logic [ENTRY_W-1:0] res_entry;
  logic [TIME_W-1:0] threshold;

  logic              tgt_ok;
  logic              can_add;
  logic              issuing;
  logic              match;
  logic              hit;
  logic              out_free;
  logic [45:0]       product;
  logic signed [47:0] until_t;
  logic signed [33:0] stay;
  logic [3:0]        pen_next;
  entry_t            upd;

  assign cfg_ready = 1'b1;
  assign q_pop = (state == S_IDLE);

  assign tgt_ok = (cmd.entry != '0) && (CW'(cmd.entry) < CW'(count));
  assign can_add = (count < EW'(TABLE_ENTRIES));
  assign issuing = (issue_idx < count);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign product = (rd_q.pen_exp == 4'd0) ? '0 : (46'(threshold) << rd_q.pen_exp);
  assign until_t = $signed({{16{rd_q.time_out[31]}}, rd_q.time_out}) + $signed({2'b00, product});
  assign stay = $signed({3'b000, cmd.now}) - $signed({{2{rd_q.time_in[31]}}, rd_q.time_in});
  assign pen_next = (rd_q.pen_exp == PEN_EXP_MAX) ? PEN_EXP_MAX : rd_q.pen_exp + 4'd1;

  always_comb begin
    match = 1'b0;
    upd = rd_q;
    case (cmd.mode)
      MODE_EVICT: begin
        match = rd_q.is_file && !rd_q.on_disk && (rd_q.is_open == pass);
        upd.time_out = {1'b0, cmd.now};
        if (!pass || (stay > $signed({3'b000, threshold}))) begin
          upd.pen_exp = 4'd0;
        end else begin
          upd.pen_exp = pen_next;
        end
      end
      MODE_BRING: begin
        match = rd_q.is_file && rd_q.handle && rd_q.on_disk &&
                ($signed({17'd0, cmd.now}) > until_t);
        upd.time_in = {1'b0, cmd.now};
      end
      MODE_ALL_MEM: begin
        match = rd_q.is_file;
        upd.on_disk = 1'b0;
        upd.pen_exp = 4'd0;
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  assign hit = pend && match && (cmd.mode != MODE_ALL_MEM);

  always_comb begin
    rd_addr = issue_idx[IDX_W-1:0];
    wr_en = 1'b0;
    wr_addr = eval_idx;
    wr_data = upd;
    unique case (state)
      S_EXEC: begin
        rd_addr = IDX_W'(cmd.entry);
        if (cmd.mode == MODE_ADD && can_add) begin
          wr_en = 1'b1;
          wr_addr = count[IDX_W-1:0];
          wr_data.is_file = cmd.is_file;
          wr_data.is_open = 1'b0;
          wr_data.handle = 1'b0;
          wr_data.on_disk = cmd.is_file & cmd.place;
          wr_data.pen_exp = 4'd0;
          wr_data.time_in = '1;
          wr_data.time_out = '1;
        end
      end
      S_TGT_WR: begin
        wr_addr = IDX_W'(cmd.entry);
        wr_data = rd_q;
        wr_en = rd_q.is_file;
        case (cmd.mode)
          MODE_OPEN: wr_data.is_open = cmd.flag;
          MODE_HANDLE: wr_data.handle = cmd.flag;
          default: wr_data.on_disk = cmd.place;
        endcase
      end
      S_SCAN: begin
        wr_en = pend && match;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= EW'(1);
      threshold <= THRESHOLD_RESET;
      pend <= 1'b0;
      pass <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {res_entry, res_found};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_in.valid) begin
            cmd <= q_in.cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_found <= 1'b0;
          res_entry <= '0;
          issue_idx <= EW'(1);
          pass <= 1'b0;
          pend <= 1'b0;
          unique case (cmd.mode)
            MODE_ADD: begin
              if (can_add) begin
                res_found <= 1'b1;
                res_entry <= ENTRY_W'(count);
                count <= count + EW'(1);
              end
              state <= S_DONE;
            end
            MODE_OPEN, MODE_HANDLE, MODE_PLACE: begin
              state <= tgt_ok ? S_TGT_WR : S_DONE;
            end
            MODE_EVICT, MODE_BRING, MODE_ALL_MEM: begin
              state <= S_SCAN;
            end
            MODE_REMOVE: begin
              count <= EW'(1);
              state <= S_DONE;
            end
          endcase
        end
        S_TGT_WR: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
            res_entry <= ENTRY_W'(eval_idx);
            pend <= 1'b0;
            state <= S_DONE;
          end else begin
            pend <= issuing;
            if (issuing) begin
              issue_idx <= issue_idx + EW'(1);
              eval_idx <= issue_idx[IDX_W-1:0];
            end else if (!pend) begin
              if (cmd.mode == MODE_EVICT && !pass) begin
                pass <= 1'b1;
                issue_idx <= EW'(1);
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/file_placement_evict_bring_policy_tb.sv]
// Self-checking testbench for the file placement evict/bring policy block.
module file_placement_evict_bring_policy_tb;
  import fpeb_pkg::*;

  localparam int unsigned NENT = TABLE_ENTRIES_DEF;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [31:0] TIME_UNSET = 32'hFFFF_FFFF;
  localparam logic [15:0] PENALTY_CAP = 16'd32768;

  typedef struct {
    logic             found;
    logic [ENTRY_W-1:0] entry;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TIME_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  file_placement_evict_bring_policy dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Shadow copy of the placement table.
  logic [TIME_W-1:0] threshold;
  int unsigned live_count;
  logic file_q[NENT];
  logic open_q[NENT];
  logic handle_q[NENT];
  logic disk_q[NENT];
  logic [31:0] in_stamp[NENT];
  logic [31:0] out_stamp[NENT];
  logic [15:0] penalty_q[NENT];

  answer_t pending_answers[$];
  int errors = 0;
  int commands_sent = 0;
  int answers_seen = 0;
  int evictions = 0;
  int brings = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  logic [TIME_W-1:0] clock_now = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic reset_table();
    threshold = THRESHOLD_RESET;
    live_count = 1;
    for (int i = 0; i < NENT; i++) begin
      file_q[i] = 0; open_q[i] = 0; handle_q[i] = 0; disk_q[i] = 0;
      in_stamp[i] = TIME_UNSET; out_stamp[i] = TIME_UNSET; penalty_q[i] = '0;
    end
  endtask

  task automatic apply_command(input cmd_t c, output answer_t a);
    longint stay;
    longint limit;
    bit ok;
    a.found = 1'b0;
    a.entry = '0;
    ok = c.entry != 0 && c.entry < live_count && file_q[c.entry];
    case (c.mode)
      MODE_ADD: begin
        if (live_count < NENT) begin
          file_q[live_count] = c.is_file;
          open_q[live_count] = 0;
          handle_q[live_count] = 0;
          disk_q[live_count] = c.is_file ? c.place : 1'b0;
          in_stamp[live_count] = TIME_UNSET;
          out_stamp[live_count] = TIME_UNSET;
          penalty_q[live_count] = '0;
          a.found = 1'b1;
          a.entry = live_count[ENTRY_W-1:0];
          live_count++;
        end
      end
      MODE_OPEN: if (ok) open_q[c.entry] = c.flag;
      MODE_HANDLE: if (ok) handle_q[c.entry] = c.flag;
      MODE_EVICT: begin
        for (int i = 1; i < live_count && !a.found; i++) begin
          if (file_q[i] && !open_q[i] && !disk_q[i]) begin
            out_stamp[i] = {1'b0, c.now};
            penalty_q[i] = '0;
            a.found = 1'b1;
            a.entry = i[ENTRY_W-1:0];
          end
        end
        for (int i = 1; i < live_count && !a.found; i++) begin
          if (file_q[i] && open_q[i] && !disk_q[i]) begin
            stay = longint'(c.now) - longint'($signed(in_stamp[i]));
            out_stamp[i] = {1'b0, c.now};
            if (stay > longint'(threshold)) penalty_q[i] = '0;
            else if (penalty_q[i] == 0) penalty_q[i] = 16'd2;
            else if (penalty_q[i] >= PENALTY_CAP / 2) penalty_q[i] = PENALTY_CAP;
            else penalty_q[i] = penalty_q[i] * 2;
            a.found = 1'b1;
            a.entry = i[ENTRY_W-1:0];
          end
        end
        if (a.found) evictions++;
      end
      MODE_BRING: begin
        for (int i = 1; i < live_count && !a.found; i++) begin
          if (file_q[i] && handle_q[i] && disk_q[i]) begin
            limit = longint'($signed(out_stamp[i])) +
                    longint'(penalty_q[i]) * longint'(threshold);
            if (longint'(c.now) > limit) begin
              in_stamp[i] = {1'b0, c.now};
              a.found = 1'b1;
              a.entry = i[ENTRY_W-1:0];
            end
          end
        end
        if (a.found) brings++;
      end
      MODE_PLACE: if (ok) disk_q[c.entry] = c.place;
      MODE_ALL_MEM: begin
        for (int i = 0; i < live_count; i++) begin
          if (file_q[i]) begin
            disk_q[i] = 0;
            penalty_q[i] = '0;
          end
        end
      end
      default: live_count = 1;
    endcase
  endtask

  task automatic send_command(input mode_t m, input int ent, input bit isf, input bit flg,
                              input bit plc, input logic [TIME_W-1:0] stamp);
    cmd_t c;
    answer_t a;
    bit rdy;
    int gap;
    c.mode = m; c.entry = ent[ENTRY_W-1:0]; c.is_file = isf; c.flag = flg;
    c.place = plc; c.now = stamp;
    if (burst_left == 0 && !sender_steady) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, c.now, c.place, c.flag, c.is_file, c.entry};
    s_axis_tuser <= c.mode;
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    apply_command(c, a);
    pending_answers.push_back(a);
    commands_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [TIME_W-1:0] v);
    bit rdy;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left <= hold_request;
      hold_request <= 0;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (receiver_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(negedge clk) begin
    answer_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        e = pending_answers.pop_front();
        if (m_axis_tdata[0] !== e.found)
          report($sformatf("found got %b want %b", m_axis_tdata[0], e.found));
        if (m_axis_tdata[7:1] !== e.entry)
          report($sformatf("entry got %0d want %0d", m_axis_tdata[7:1], e.entry));
      end
    end
  end

  task automatic test_directed();
    send_command(MODE_ADD, 0, 1, 0, 0, 31'd0);
    send_command(MODE_ADD, 0, 1, 0, 1, 31'd0);
    send_command(MODE_ADD, 0, 0, 1, 1, 31'd0);
    send_command(MODE_OPEN, 0, 0, 1, 0, 31'd0);
    send_command(MODE_HANDLE, 3, 0, 1, 0, 31'd0);
    send_command(MODE_PLACE, 127, 0, 1, 1, 31'd0);
    send_command(MODE_HANDLE, 2, 0, 1, 0, 31'd0);
    send_command(MODE_BRING, 0, 0, 0, 0, 31'd0);
    send_command(MODE_BRING, 0, 0, 0, 0, 31'd5);
    send_command(MODE_EVICT, 0, 0, 0, 0, 31'd10);
    send_command(MODE_OPEN, 1, 0, 1, 0, 31'd0);
    send_command(MODE_EVICT, 0, 0, 0, 0, 31'd20);
    send_command(MODE_EVICT, 0, 0, 0, 0, TIME_MAX);
    send_command(MODE_PLACE, 1, 0, 0, 1, 31'd0);
    send_command(MODE_EVICT, 0, 0, 0, 0, 31'd30);
    send_command(MODE_ALL_MEM, 0, 0, 0, 0, 31'd0);
    send_command(MODE_BRING, 127, 1, 1, 1, TIME_MAX);
    send_command(MODE_REMOVE, 0, 0, 0, 0, 31'd0);
    send_command(MODE_OPEN, 1, 0, 1, 0, 31'd0);
    send_command(MODE_ADD, 0, 1, 0, 0, TIME_MAX);
    send_command(MODE_EVICT, 0, 0, 0, 0, 31'd40);
  endtask

  // Repeated short stays on one open file drive its penalty up to the cap.
  task automatic test_penalty_cap();
    send_command(MODE_REMOVE, 0, 0, 0, 0, 31'd0);
    send_command(MODE_ADD, 0, 1, 0, 1, 31'd0);
    send_command(MODE_OPEN, 1, 0, 1, 0, 31'd0);
    send_command(MODE_HANDLE, 1, 0, 1, 0, 31'd0);
    send_command(MODE_PLACE, 1, 0, 0, 0, 31'd0);
    for (int k = 0; k < 17; k++) send_command(MODE_EVICT, 0, 0, 0, 0, 31'd100);
    send_command(MODE_PLACE, 1, 0, 0, 1, 31'd0);
    send_command(MODE_BRING, 0, 0, 0, 0, 31'd1000);
    send_command(MODE_BRING, 0, 0, 0, 0, TIME_MAX);
  endtask

  task automatic test_table_full();
    send_command(MODE_REMOVE, 0, 0, 0, 0, 31'd0);
    for (int k = 0; k < NENT + 2; k++)
      send_command(MODE_ADD, 0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)),
                   31'd0);
    send_command(MODE_OPEN, 127, 0, 1, 0, 31'd0);
    send_command(MODE_EVICT, 0, 0, 0, 0, 31'd7);
  endtask

  task automatic random_command();
    int r;
    int ent;
    logic [TIME_W-1:0] stamp;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) ent = $urandom_range(0, NENT - 1);
    else ent = $urandom_range(0, live_count);
    if ($urandom_range(0, 19) == 0) begin
      stamp = TIME_W'($urandom);
    end else begin
      clock_now = clock_now + TIME_W'($urandom_range(0, 1500));
      stamp = clock_now;
    end
    if (r < 16) send_command(MODE_ADD, ent, $urandom_range(0, 5) != 0,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), stamp);
    else if (r < 31) send_command(MODE_OPEN, ent, 0, 1'($urandom_range(0, 1)), 0, stamp);
    else if (r < 45) send_command(MODE_HANDLE, ent, 0, $urandom_range(0, 3) != 0, 0, stamp);
    else if (r < 62) send_command(MODE_EVICT, ent, 0, 0, 0, stamp);
    else if (r < 79) send_command(MODE_BRING, ent, 0, 0, 0, stamp);
    else if (r < 94) send_command(MODE_PLACE, ent, 0, 0, 1'($urandom_range(0, 1)), stamp);
    else if (r < 97) send_command(MODE_ALL_MEM, ent, 0, 0, 0, stamp);
    else if (live_count > 20 || r == 99) send_command(MODE_REMOVE, ent, 0, 0, 0, stamp);
    else send_command(MODE_ADD, ent, 1, 0, 0, stamp);
  endtask

  task automatic test_random_phase(input logic [TIME_W-1:0] thr, input int count);
    write_threshold(thr);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        sender_steady = $urandom_range(0, 3) == 0;
        receiver_steady = $urandom_range(0, 3) == 0;
      end
      random_command();
    end
  endtask

  task automatic test_backpressure();
    hold_request = 400;
    for (int k = 0; k < 30; k++) random_command();
  endtask

  initial begin
    reset_table();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_penalty_cap();
    test_table_full();
    test_random_phase(31'd0, 280);
    test_random_phase(TIME_MAX, 280);
    test_backpressure();
    test_random_phase(31'd1, 280);
    test_random_phase(TIME_W'($urandom_range(2, 5000)), 280);
    test_random_phase(THRESHOLD_RESET, 280);
    drain();
    $display("Covered %0d commands over directed, full table, penalty cap and random phases;",
             commands_sent);
    $display("%0d results checked, %0d evictions and %0d brings predicted.",
             answers_seen, evictions, brings);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
